/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL, included by array_pool_indexed_linked_list.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/apll_pkg.sv */
// Package for the pooled linked list: command and status codes, defaults.
// No dependencies.
package apll_pkg;
    localparam int POOL_SIZE_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int VAL_W    = 32;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;
endpackage

/* hw/rtl/array_pool_indexed_linked_list.sv */
// Top level of the pooled doubly linked list; holds the node memories and the sequencer.
// Depends on apll_pkg and assert_macros.svh.
//
// Each command is one transfer on s_axis and gives one transfer on m_axis. s_axis_tready
// stays low from the accepting edge until that result has been taken. The memories have
// registered read data, so a walk from the head passes S_WALK and S_DWAIT for each node.
// Append passes S_WWAIT, S_LINK1 and, unless the list was empty, S_LINK2; get and set
// walk to position p and pass S_DRD and S_ACT; remove adds S_LINK1, insert S_LINK1 and
// S_LINK2; search passes S_SRD and S_SCMP for each of the k nodes compared, at most the
// count; a bad position, full pool, empty search or unused command goes straight to S_OUT,
// which raises m_axis_tvalid. After reset a clearing pass builds the free chain and clears
// the back links of all nodes, one node per cycle, while s_axis_tready stays low.
`include "assert_macros.svh"
module array_pool_indexed_linked_list #(
    parameter int POOL_SIZE  = apll_pkg::POOL_SIZE_DEF,
    parameter int DATA_WIDTH = apll_pkg::DATA_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], position[12:3], value[44:13], zero fill to 48
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], data_out[33:2], found_position[43:34], count[54:44], zero fill to 56
    output logic [55:0] m_axis_tdata
);
    import apll_pkg::*;

    localparam int IW = $clog2(POOL_SIZE + 1);      // node index with a null code
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [IW-1:0] NIL = {IW{1'b1}};

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_WALK = 4'd2, S_WWAIT = 4'd3,
                           S_ACT = 4'd4, S_SRD = 4'd5, S_SCMP = 4'd6, S_LINK1 = 4'd7,
                           S_LINK2 = 4'd8, S_OUT = 4'd9, S_DRD = 4'd10, S_DWAIT = 4'd11;

    logic [DATA_WIDTH-1:0] data_mem [POOL_SIZE];
    logic [IW-1:0] next_mem [POOL_SIZE];
    logic [IW-1:0] prev_mem [POOL_SIZE];

    logic [3:0] state_reg, state_next;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next, free_reg, free_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [VAL_W-1:0] dout_reg, dout_next;
    logic [POS_W-1:0] fpos_reg, fpos_next;
    logic ovalid_reg, ovalid_next;
    logic [IW-1:0] pv_reg, pv_next, nx_reg, nx_next;

    // One read address shared by all three memories, registered read data.
    logic [IW-1:0] raddr;
    logic [IW-1:0] nrd, prd;
    logic [DATA_WIDTH-1:0] drd;
    // Write ports: next, prev and data memories, one write each per cycle.
    logic nwe, pwe, dwe;
    logic [IW-1:0] nwa, nwd, pwa, pwd, dwa;
    logic [DATA_WIDTH-1:0] dwd;

    logic [CMD_W-1:0] in_cmd;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    assign in_cmd = s_axis_tdata[2:0];
    assign in_pos = s_axis_tdata[12:3];
    assign in_val = s_axis_tdata[44:13];

    always_ff @(posedge clk)
    begin
        nrd <= next_mem[raddr[$clog2(POOL_SIZE)-1:0]];
        prd <= prev_mem[raddr[$clog2(POOL_SIZE)-1:0]];
        drd <= data_mem[raddr[$clog2(POOL_SIZE)-1:0]];
        if (nwe)
        begin
            next_mem[nwa[$clog2(POOL_SIZE)-1:0]] <= nwd;
        end
        if (pwe)
        begin
            prev_mem[pwa[$clog2(POOL_SIZE)-1:0]] <= pwd;
        end
        if (dwe)
        begin
            data_mem[dwa[$clog2(POOL_SIZE)-1:0]] <= dwd;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {1'b0, cnt_reg[COUNT_W-1:0], fpos_reg, dout_reg, st_reg};

    always_comb
    begin
        state_next = state_reg; head_next = head_reg; tail_next = tail_reg;
        free_next = free_reg; cnt_next = cnt_reg; clr_next = clr_reg;
        cur_next = cur_reg; step_next = step_reg; cmd_next = cmd_reg;
        pos_next = pos_reg; val_next = val_reg; st_next = st_reg;
        dout_next = dout_reg; fpos_next = fpos_reg; ovalid_next = ovalid_reg;
        pv_next = pv_reg; nx_next = nx_reg;
        raddr = cur_reg;
        nwe = 1'b0; pwe = 1'b0; dwe = 1'b0;
        nwa = cur_reg; nwd = NIL; pwa = cur_reg; pwd = NIL; dwa = cur_reg;
        dwd = val_reg;
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                nwe = 1'b1; pwe = 1'b1; nwa = clr_reg; pwa = clr_reg;
                nwd = (clr_reg == IW'(POOL_SIZE - 1)) ? NIL : clr_reg + 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(POOL_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    cmd_next = in_cmd; pos_next = in_pos;
                    val_next = DATA_WIDTH'(in_val);
                    st_next = ST_OK; dout_next = '0; fpos_next = '0;
                    cur_next = head_reg; step_next = '0;
                    state_next = S_OUT;
                    if (in_cmd == CMD_APPEND)
                    begin
                        if (free_reg == NIL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            cur_next = free_reg;
                            state_next = S_WWAIT;   // read next link of free head
                        end
                    end
                    else if (in_cmd == CMD_SEARCH)
                    begin
                        st_next = ST_NOT_FOUND;
                        if (cnt_reg != '0)
                        begin
                            state_next = S_SRD;
                        end
                    end
                    else if (in_cmd == CMD_INSERT || in_cmd == CMD_GET ||
                             in_cmd == CMD_SET || in_cmd == CMD_REMOVE)
                    begin
                        if (CW'(in_pos) >= cnt_reg)
                        begin
                            st_next = ST_BAD_POS;
                        end
                        else if (in_cmd == CMD_INSERT && free_reg == NIL)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = (in_pos == '0) ? S_DRD : S_WALK;
                        end
                    end
                end
            end
            S_WALK:
            begin
                raddr = cur_reg;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                // nrd holds next of cur; advance one position.
                cur_next = nrd;
                step_next = step_reg + 1'b1;
                state_next = (CW'(pos_reg) == step_reg + 1'b1) ? S_DRD : S_WALK;
            end
            S_DRD:
            begin
                raddr = cur_reg;
                state_next = S_ACT;
            end
            S_WWAIT:
            begin
                raddr = cur_reg;   // free head
                state_next = S_LINK1;
            end
            S_SRD:
            begin
                raddr = cur_reg;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (drd == val_reg)
                begin
                    st_next = ST_OK;
                    fpos_next = step_reg[POS_W-1:0];
                    state_next = S_OUT;
                end
                else if (step_reg + 1'b1 == cnt_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cur_next = nrd;
                    step_next = step_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_ACT:
            begin
                // drd, nrd, prd are those of the node at the position.
                pv_next = prd; nx_next = nrd;
                if (cmd_reg == CMD_INSERT)
                begin
                    // read the free head to learn the new free head
                    raddr = free_reg;
                    state_next = S_LINK1;
                end
                else
                begin
                    dout_next = VAL_W'(drd);
                    state_next = S_OUT;
                    if (cmd_reg == CMD_SET)
                    begin
                        dwe = 1'b1;
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        nwe = 1'b1; nwd = free_reg;
                        pwe = 1'b1; pwd = NIL;
                        free_next = cur_reg;
                        cnt_next = cnt_reg - 1'b1;
                        state_next = S_LINK1;
                    end
                end
            end
            S_LINK1:
            begin
                state_next = S_OUT;
                if (cmd_reg == CMD_APPEND)
                begin
                    // cur is the new node, nrd its free successor
                    free_next = nrd;
                    dwe = 1'b1;
                    nwe = 1'b1; nwd = NIL;
                    pwe = 1'b1; pwd = tail_reg;
                    if (tail_reg == NIL)
                    begin
                        head_next = cur_reg;
                    end
                    else
                    begin
                        state_next = S_LINK2;
                    end
                    pv_next = tail_reg;
                    tail_next = cur_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    // new node is free_reg; cur is the node at the position
                    free_next = nrd;
                    dwe = 1'b1; dwa = free_reg;
                    nwe = 1'b1; nwa = free_reg; nwd = cur_reg;
                    pwe = 1'b1; pwa = free_reg; pwd = pv_reg;
                    nx_next = free_reg;
                    cnt_next = cnt_reg + 1'b1;
                    if (pv_reg == NIL)
                    begin
                        head_next = free_reg;
                    end
                    state_next = S_LINK2;
                end
                else
                begin
                    // remove: splice neighbors
                    if (pv_reg == NIL)
                    begin
                        head_next = nx_reg;
                    end
                    else
                    begin
                        nwe = 1'b1; nwa = pv_reg; nwd = nx_reg;
                    end
                    if (nx_reg == NIL)
                    begin
                        tail_next = pv_reg;
                    end
                    else
                    begin
                        pwe = 1'b1; pwa = nx_reg; pwd = pv_reg;
                    end
                end
            end
            S_LINK2:
            begin
                state_next = S_OUT;
                if (cmd_reg == CMD_APPEND)
                begin
                    nwe = 1'b1; nwa = pv_reg; nwd = cur_reg;
                end
                else
                begin
                    // insert: nx holds the new node
                    pwe = 1'b1; pwa = cur_reg; pwd = nx_reg;
                    if (pv_reg != NIL)
                    begin
                        nwe = 1'b1; nwa = pv_reg; nwd = nx_reg;
                    end
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR; head_reg <= NIL; tail_reg <= NIL; free_reg <= '0;
            cnt_reg <= '0; clr_reg <= '0; ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; head_reg <= head_next; tail_reg <= tail_next;
            free_reg <= free_next; cnt_reg <= cnt_next; clr_reg <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; step_reg <= step_next; cmd_reg <= cmd_next;
        pos_reg <= pos_next; val_reg <= val_next; st_reg <= st_next;
        dout_reg <= dout_next; fpos_reg <= fpos_next; pv_reg <= pv_next;
        nx_reg <= nx_next;
    end

    `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(POOL_SIZE), "count above pool")
    `ASSERT_IMPL(a_empty_nil, clk, rst_n, cnt_reg == '0 && state_reg == S_IDLE,
                 head_reg == NIL && tail_reg == NIL, "empty list with head")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                 "result dropped")
endmodule

/* tb/sv/tb_array_pool_indexed_linked_list.sv */
// Testbench for the pooled doubly linked list: directed table, then random commands.
// Depends on apll_pkg and array_pool_indexed_linked_list; checks each response in order.
`timescale 1ns / 1ps
module tb_array_pool_indexed_linked_list;
    import apll_pkg::*;

    localparam int NPOOL = 1024;
    // Command codes that the block treats as no operation.
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [10:0] count;
        logic [9:0]  found_position;
        logic [31:0] data_out;
        logic [1:0]  status;
    } resp_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [9:0]  position;
        logic [31:0] value;
        logic        has_exp;
        logic [1:0]  exp_status;
        logic [31:0] exp_data;
        logic [10:0] exp_count;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    array_pool_indexed_linked_list uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow copy of the list: the element sequence alone decides every result.
    logic [31:0] list_vals[$];
    resp_t       pending_resps[$];
    int          errors;
    int          n_recv;
    int          n_sent;
    bit          hold_off;
    int          cmd_hist[8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic resp_t list_apply(logic [2:0] cmd, logic [9:0] pos, logic [31:0] val);
        resp_t r;
        r = '0;
        case (cmd)
            CMD_APPEND:
                if (list_vals.size() >= NPOOL) r.status = ST_FULL;
                else list_vals.push_back(val);
            CMD_INSERT:
                if (pos >= list_vals.size()) r.status = ST_BAD_POS;
                else if (list_vals.size() >= NPOOL) r.status = ST_FULL;
                else list_vals.insert(pos, val);
            CMD_GET, CMD_SET, CMD_REMOVE:
                if (pos >= list_vals.size()) r.status = ST_BAD_POS;
                else
                begin
                    r.data_out = list_vals[pos];
                    if (cmd == CMD_SET) list_vals[pos] = val;
                    else if (cmd == CMD_REMOVE) list_vals.delete(pos);
                end
            CMD_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < list_vals.size(); i++)
                    if (list_vals[i] == val)
                    begin
                        r.status = ST_OK;
                        r.found_position = 10'(i);
                        break;
                    end
            end
            default: ;
        endcase
        r.count = 11'(list_vals.size());
        return r;
    endfunction

    // tvalid stays high across back-to-back transfers and drops only for a gap.
    task automatic send_cmd(logic [2:0] cmd, logic [9:0] pos, logic [31:0] val);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, pos, cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_resps.push_back(list_apply(cmd, pos, val));
        cmd_hist[cmd]++;
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_resps.size() != 0) @(posedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off requested by the sender.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 1);
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        resp_t got;
        resp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[54:0];
            n_recv++;
            if (pending_resps.size() == 0)
            begin
                $error("response with no command outstanding");
                errors++;
            end
            else
            begin
                want = pending_resps.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.data_out !== want.data_out)
                begin
                    $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                    errors++;
                end
                if (got.found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, got.found_position);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #80ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        step_t       dir_steps[$];
        step_t       s;
        resp_t       chk;
        logic [2:0]  c;
        logic [9:0]  p;
        logic [31:0] v;
        int          sz;
        int          pick;

        errors = 0;
        n_recv = 0;
        n_sent = 0;
        hold_off = 1'b0;
        foreach (cmd_hist[i]) cmd_hist[i] = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; rows with has_exp = 0 rely on the shadow list alone.
        dir_steps = '{
            '{CMD_GET,      10'd0,    32'h0,        1'b1, ST_BAD_POS,   32'h0, 11'd0},
            '{CMD_INSERT,   10'd0,    32'h5,        1'b1, ST_BAD_POS,   32'h0, 11'd0},
            '{CMD_REMOVE,   10'd1023, 32'h0,        1'b1, ST_BAD_POS,   32'h0, 11'd0},
            '{CMD_SEARCH,   10'd0,    32'h0,        1'b1, ST_NOT_FOUND, 32'h0, 11'd0},
            '{CMD_UNUSED_A, 10'd1023, 32'hFFFFFFFF, 1'b1, ST_OK,        32'h0, 11'd0},
            '{CMD_APPEND,   10'd0,    32'hFFFFFFFF, 1'b1, ST_OK,        32'h0, 11'd1},
            '{CMD_REMOVE,   10'd0,    32'h0,        1'b1, ST_OK,  32'hFFFFFFFF, 11'd0},
            '{CMD_APPEND,   10'd1023, 32'h0,        1'b1, ST_OK,        32'h0, 11'd1},
            '{CMD_APPEND,   10'd0,    32'hA5A5A5A5, 1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_INSERT,   10'd1,    32'h12345678, 1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_INSERT,   10'd0,    32'h5A5A5A5A, 1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_SET,      10'd3,    32'hDEADBEEF, 1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_GET,      10'd3,    32'h0,        1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_SEARCH,   10'd0,    32'hDEADBEEF, 1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_SEARCH,   10'd0,    32'h0,        1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_REMOVE,   10'd1,    32'h0,        1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_GET,      10'd4,    32'h0,        1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_UNUSED_B, 10'd1,    32'h1,        1'b0, 2'd0, 32'h0, 11'd0},
            '{CMD_REMOVE,   10'd2,    32'h0,        1'b0, 2'd0, 32'h0, 11'd0}
        };
        foreach (dir_steps[i])
        begin
            s = dir_steps[i];
            send_cmd(s.cmd, s.position, s.value);
            if (s.has_exp)
            begin
                // The row's typed-in response replaces the predicted one.
                void'(pending_resps.pop_back());
                chk = '{status: s.exp_status, data_out: s.exp_data,
                        found_position: 10'd0, count: s.exp_count};
                pending_resps.push_back(chk);
            end
        end

        // Random commands on a short list; the receiver holds off for a long stretch first.
        wait_drained();
        hold_off = 1'b1;
        repeat (560)
        begin
            sz = list_vals.size();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                c = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
            else
                c = 3'($urandom_range(0, 5));
            if (sz > 40 && c == CMD_APPEND) c = CMD_REMOVE;
            if (pick >= 90 || sz == 0) p = 10'($urandom_range(0, 1023));
            else p = 10'($urandom_range(0, sz - 1));
            v = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 31);
            if (c == CMD_SEARCH && sz != 0 && $urandom_range(0, 1))
                v = list_vals[$urandom_range(0, sz - 1)];
            send_cmd(c, p, v);
        end

        wait_drained();
        repeat (2200) @(posedge clk);
        $display("Commands sent %0d, responses %0d; append %0d insert %0d get %0d",
                 n_sent, n_recv, cmd_hist[CMD_APPEND], cmd_hist[CMD_INSERT],
                 cmd_hist[CMD_GET]);
        $display("set %0d remove %0d search %0d unused %0d, with one long receiver stall",
                 cmd_hist[CMD_SET], cmd_hist[CMD_REMOVE], cmd_hist[CMD_SEARCH],
                 cmd_hist[CMD_UNUSED_A] + cmd_hist[CMD_UNUSED_B]);
        if (errors == 0 && pending_resps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/apll_pkg.sv
hw/rtl/array_pool_indexed_linked_list.sv
tb/sv/tb_array_pool_indexed_linked_list.sv
